// ===== hdl/djsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// djsg_pkg
// Types, constants and arithmetic helpers shared by the wrist step generator.
// ----------------------------------------------------------------------------
package djsg_pkg;

   localparam int DATA_W    = 32;   // Q16.16 velocity and position words
   localparam int STEP_W    = 16;   // step size register
   localparam int CMD_W     = 2;    // request command code
   localparam int CSR_IDX_W = 2;    // register index
   localparam int MAG_W     = 33;   // magnitude of a sum of two words
   localparam int SUM_W     = 34;   // signed sum of two words
   localparam int PROD_W    = 64;   // shared multiplier result

   localparam int TICKS_PER_SECOND_DEFAULT = 1000;

   localparam logic [DATA_W-1:0] SPEED_GAIN_RESET   = 32'd41200;
   localparam logic [DATA_W-1:0] INVERSE_GAIN_RESET = 32'd104248;
   localparam logic [STEP_W-1:0] STEP_SIZE_RESET    = 16'd328;

   localparam logic [DATA_W-1:0] POS_MAX  = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] NEG_MIN  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] TICK_MAX = 32'hffff_ffff;

   typedef enum logic [CMD_W-1:0] {
      CMD_ROLL = 2'd0,
      CMD_TILT = 2'd1,
      CMD_TICK = 2'd2
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPEED_GAIN   = 2'd0,
      REG_INVERSE_GAIN = 2'd1,
      REG_STEP_SIZE    = 2'd2
   } reg_index_type;

   // one job is one pass of the shared multiplier
   typedef enum logic [2:0] {
      JOB_MIX_A = 3'd0,
      JOB_MIX_B = 3'd1,
      JOB_CHK_A = 3'd2,
      JOB_CHK_B = 3'd3,
      JOB_ROLL  = 3'd4,
      JOB_TILT  = 3'd5
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OP,
      S_MUL,
      S_WR,
      S_STEP,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic    load_roll;
      logic    load_tilt;
      logic    tick;
      logic    op_load;
      logic    mul;
      logic    wr;
      logic    step;
      logic    emit;
      job_type job;
   } dp_cmd_type;

   typedef struct packed {
      logic any_step;
      logic out_busy;
   } dp_status_type;

   // shift a product magnitude right by 16 or 17, then apply the sign and
   // saturate to a signed word
   function automatic logic [DATA_W-1:0] sat_shift(input logic [PROD_W-1:0] prod,
                                                   input logic neg,
                                                   input logic half);
      logic [PROD_W-1:0] q;
      logic [DATA_W-1:0] r;
      q = half ? (prod >> 17) : (prod >> 16);
      if (!neg) begin
         r = (q > PROD_W'(POS_MAX)) ? POS_MAX : q[DATA_W-1:0];
      end else begin
         r = (q >= PROD_W'(NEG_MIN)) ? NEG_MIN : (~q[DATA_W-1:0] + 32'd1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/djsg_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// djsg_req_if
// Request channel: joint velocity commands and millisecond ticks.
// ----------------------------------------------------------------------------
interface djsg_req_if;
   logic                             valid;
   logic                             ready;
   logic [djsg_pkg::CMD_W-1:0]       command;
   logic signed [djsg_pkg::DATA_W-1:0] velocity;

   modport source (output valid, output command, output velocity, input ready);
   modport sink   (input valid, input command, input velocity, output ready);
endinterface
`default_nettype wire

// ===== hdl/djsg_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// djsg_rsp_if
// Response channel: one transaction per motor step.
// ----------------------------------------------------------------------------
interface djsg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               motor_axis;
   logic signed [djsg_pkg::DATA_W-1:0] motor_position;
   logic signed [djsg_pkg::DATA_W-1:0] roll_position;
   logic signed [djsg_pkg::DATA_W-1:0] tilt_position;
   logic                               last;

   modport source (output valid, output motor_axis, output motor_position,
                   output roll_position, output tilt_position, output last,
                   input ready);
   modport sink   (input valid, input motor_axis, input motor_position,
                   input roll_position, input tilt_position, input last,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/djsg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// djsg_ctrl
// Sequencer: runs mix, threshold and joint jobs through the shared multiplier.
// ----------------------------------------------------------------------------
module djsg_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [djsg_pkg::CMD_W-1:0] req_command,
   output logic                            req_ready,
   input  wire logic                       csr_gain_write,
   input  wire djsg_pkg::dp_status_type    status,
   output djsg_pkg::dp_cmd_type            cmd
);

   djsg_pkg::state_type state_ff, state_in;
   djsg_pkg::job_type   job_ff, job_in;
   logic                remix_pending_ff, remix_pending_in;
   logic                remix_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= djsg_pkg::S_IDLE;
         job_ff           <= djsg_pkg::JOB_MIX_A;
         remix_pending_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         job_ff           <= job_in;
         remix_pending_ff <= remix_pending_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      remix_start = 1'b0;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.job     = job_ff;

      unique case (state_ff)
         djsg_pkg::S_IDLE: begin
            if (remix_pending_ff) begin
               remix_start = 1'b1;
               job_in      = djsg_pkg::JOB_MIX_A;
               state_in    = djsg_pkg::S_OP;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  unique case (djsg_pkg::command_type'(req_command))
                     djsg_pkg::CMD_ROLL: begin
                        cmd.load_roll = 1'b1;
                        job_in        = djsg_pkg::JOB_MIX_A;
                        state_in      = djsg_pkg::S_OP;
                     end
                     djsg_pkg::CMD_TILT: begin
                        cmd.load_tilt = 1'b1;
                        job_in        = djsg_pkg::JOB_MIX_A;
                        state_in      = djsg_pkg::S_OP;
                     end
                     djsg_pkg::CMD_TICK: begin
                        cmd.tick = 1'b1;
                        job_in   = djsg_pkg::JOB_CHK_A;
                        state_in = djsg_pkg::S_OP;
                     end
                     default: begin
                        state_in = djsg_pkg::S_IDLE;
                     end
                  endcase
               end
            end
         end
         djsg_pkg::S_OP: begin
            cmd.op_load = 1'b1;
            state_in    = djsg_pkg::S_MUL;
         end
         djsg_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = djsg_pkg::S_WR;
         end
         djsg_pkg::S_WR: begin
            cmd.wr = 1'b1;
            unique case (job_ff)
               djsg_pkg::JOB_MIX_A: begin
                  job_in   = djsg_pkg::JOB_MIX_B;
                  state_in = djsg_pkg::S_OP;
               end
               djsg_pkg::JOB_MIX_B: state_in = djsg_pkg::S_IDLE;
               djsg_pkg::JOB_CHK_A: begin
                  job_in   = djsg_pkg::JOB_CHK_B;
                  state_in = djsg_pkg::S_OP;
               end
               djsg_pkg::JOB_CHK_B: state_in = djsg_pkg::S_STEP;
               djsg_pkg::JOB_ROLL: begin
                  job_in   = djsg_pkg::JOB_TILT;
                  state_in = djsg_pkg::S_OP;
               end
               djsg_pkg::JOB_TILT: state_in = djsg_pkg::S_EMIT;
               default:            state_in = djsg_pkg::S_IDLE;
            endcase
         end
         djsg_pkg::S_STEP: begin
            if (status.any_step) begin
               cmd.step = 1'b1;
               job_in   = djsg_pkg::JOB_ROLL;
               state_in = djsg_pkg::S_OP;
            end else begin
               state_in = djsg_pkg::S_IDLE;
            end
         end
         djsg_pkg::S_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = djsg_pkg::S_STEP;
            end
         end
         default: state_in = djsg_pkg::S_IDLE;
      endcase

      remix_pending_in = csr_gain_write | (remix_pending_ff & ~remix_start);
   end

endmodule
`default_nettype wire

// ===== hdl/djsg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// djsg_dp
// Datapath: config, velocities, motor state, shared multiplier, output stage.
// ----------------------------------------------------------------------------
module djsg_dp #(
   parameter int TICKS_PER_SECOND = djsg_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire djsg_pkg::dp_cmd_type              cmd,
   output djsg_pkg::dp_status_type                status,
   input  wire logic                              csr_write_enable,
   input  wire logic [djsg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [djsg_pkg::DATA_W-1:0]       csr_write_data,
   input  wire logic signed [djsg_pkg::DATA_W-1:0] req_velocity,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic                                   rsp_motor_axis,
   output logic signed [djsg_pkg::DATA_W-1:0]     rsp_motor_position,
   output logic signed [djsg_pkg::DATA_W-1:0]     rsp_roll_position,
   output logic signed [djsg_pkg::DATA_W-1:0]     rsp_tilt_position,
   output logic                                   rsp_last
);

   localparam int DW       = djsg_pkg::DATA_W;
   localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
   localparam int THRESH_W = djsg_pkg::STEP_W + TPS_W;
   localparam logic [THRESH_W-1:0] TPS_K = THRESH_W'(TICKS_PER_SECOND);

   // configuration
   logic [DW-1:0]                     gain_ff, gain_in;
   logic [DW-1:0]                     inv_gain_ff, inv_gain_in;
   logic [djsg_pkg::STEP_W-1:0]       step_size_ff, step_size_in;
   logic [THRESH_W-1:0]               thresh_ff, thresh_in;

   // block state
   logic signed [DW-1:0]              roll_vel_ff, roll_vel_in;
   logic signed [DW-1:0]              tilt_vel_ff, tilt_vel_in;
   logic signed [DW-1:0]              mv_ff [2];
   logic signed [DW-1:0]              mv_in [2];
   logic signed [DW-1:0]              place_ff [2];
   logic signed [DW-1:0]              place_in [2];
   logic [DW-1:0]                     ticks_ff [2];
   logic [DW-1:0]                     ticks_in [2];
   logic [1:0]                        step_ff, step_in;
   logic                              axis_ff, axis_in;

   // multiplier pipeline
   logic [djsg_pkg::MAG_W-1:0]        mag_ff, mag_in;
   logic                              neg_ff, neg_in;
   logic [DW-1:0]                     fac_ff, fac_in;
   logic [djsg_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [DW-1:0]                     roll_res_ff, roll_res_in;
   logic [DW-1:0]                     tilt_res_ff, tilt_res_in;

   // output stage
   logic                              out_valid_ff, out_valid_in;
   logic                              out_axis_ff, out_axis_in;
   logic [DW-1:0]                     out_motor_ff, out_motor_in;
   logic [DW-1:0]                     out_roll_ff, out_roll_in;
   logic [DW-1:0]                     out_tilt_ff, out_tilt_in;
   logic                              out_last_ff, out_last_in;

   // combinational helpers
   logic signed [djsg_pkg::SUM_W-1:0] op_sum;
   logic [djsg_pkg::SUM_W-1:0]        op_abs;
   logic [DW-1:0]                     mv_abs [2];
   logic [DW-1:0]                     wr_val;
   logic                              step_hit;
   logic                              step_m;
   logic signed [DW:0]                place_sum;
   logic signed [DW:0]                step_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= djsg_pkg::SPEED_GAIN_RESET;
         inv_gain_ff  <= djsg_pkg::INVERSE_GAIN_RESET;
         step_size_ff <= djsg_pkg::STEP_SIZE_RESET;
         thresh_ff    <= THRESH_W'(djsg_pkg::STEP_SIZE_RESET) * TPS_K;
         roll_vel_ff  <= '0;
         tilt_vel_ff  <= '0;
         mv_ff[0]     <= '0;
         mv_ff[1]     <= '0;
         place_ff[0]  <= '0;
         place_ff[1]  <= '0;
         ticks_ff[0]  <= '0;
         ticks_ff[1]  <= '0;
         step_ff      <= '0;
         axis_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         inv_gain_ff  <= inv_gain_in;
         step_size_ff <= step_size_in;
         thresh_ff    <= thresh_in;
         roll_vel_ff  <= roll_vel_in;
         tilt_vel_ff  <= tilt_vel_in;
         mv_ff        <= mv_in;
         place_ff     <= place_in;
         ticks_ff     <= ticks_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      fac_ff       <= fac_in;
      prod_ff      <= prod_in;
      roll_res_ff  <= roll_res_in;
      tilt_res_ff  <= tilt_res_in;
      out_axis_ff  <= out_axis_in;
      out_motor_ff <= out_motor_in;
      out_roll_ff  <= out_roll_in;
      out_tilt_ff  <= out_tilt_in;
      out_last_ff  <= out_last_in;
   end

   // register writes
   always_comb begin
      gain_in      = gain_ff;
      inv_gain_in  = inv_gain_ff;
      step_size_in = step_size_ff;
      thresh_in    = thresh_ff;
      if (csr_write_enable) begin
         unique case (djsg_pkg::reg_index_type'(csr_index))
            djsg_pkg::REG_SPEED_GAIN:   gain_in = csr_write_data;
            djsg_pkg::REG_INVERSE_GAIN: inv_gain_in = csr_write_data;
            djsg_pkg::REG_STEP_SIZE: begin
               step_size_in = csr_write_data[djsg_pkg::STEP_W-1:0];
               thresh_in    = THRESH_W'(csr_write_data[djsg_pkg::STEP_W-1:0]) * TPS_K;
            end
            default: ;
         endcase
      end
   end

   // operand stage: signed sum, magnitude and second factor of the job
   always_comb begin
      mv_abs[0] = mv_ff[0][DW-1] ? (~mv_ff[0] + 32'd1) : mv_ff[0];
      mv_abs[1] = mv_ff[1][DW-1] ? (~mv_ff[1] + 32'd1) : mv_ff[1];
      op_sum    = '0;
      fac_in    = fac_ff;
      unique case (cmd.job)
         djsg_pkg::JOB_MIX_A: begin
            op_sum = djsg_pkg::SUM_W'(tilt_vel_ff) - djsg_pkg::SUM_W'(roll_vel_ff);
            fac_in = gain_ff;
         end
         djsg_pkg::JOB_MIX_B: begin
            op_sum = -djsg_pkg::SUM_W'(roll_vel_ff) - djsg_pkg::SUM_W'(tilt_vel_ff);
            fac_in = gain_ff;
         end
         djsg_pkg::JOB_CHK_A: begin
            op_sum = {2'b00, ticks_ff[0]};
            fac_in = mv_abs[0];
         end
         djsg_pkg::JOB_CHK_B: begin
            op_sum = {2'b00, ticks_ff[1]};
            fac_in = mv_abs[1];
         end
         djsg_pkg::JOB_ROLL: begin
            op_sum = -djsg_pkg::SUM_W'(place_ff[0]) - djsg_pkg::SUM_W'(place_ff[1]);
            fac_in = inv_gain_ff;
         end
         djsg_pkg::JOB_TILT: begin
            op_sum = djsg_pkg::SUM_W'(place_ff[0]) - djsg_pkg::SUM_W'(place_ff[1]);
            fac_in = inv_gain_ff;
         end
         default: ;
      endcase
      op_abs = op_sum[djsg_pkg::SUM_W-1] ? -op_sum : op_sum;
      mag_in = op_abs[djsg_pkg::MAG_W-1:0];
      neg_in = op_sum[djsg_pkg::SUM_W-1];
      if (!cmd.op_load) begin
         mag_in = mag_ff;
         neg_in = neg_ff;
         fac_in = fac_ff;
      end
   end

   // shared multiplier; a magnitude of exactly 2^32 has a zero low word
   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul) begin
         if (mag_ff[djsg_pkg::MAG_W-1]) begin
            prod_in = {fac_ff, 32'd0};
         end else begin
            prod_in = djsg_pkg::PROD_W'(mag_ff[DW-1:0]) * djsg_pkg::PROD_W'(fac_ff);
         end
      end
   end

   // write back, step and tick
   always_comb begin
      wr_val   = djsg_pkg::sat_shift(prod_ff, neg_ff,
                                     (cmd.job == djsg_pkg::JOB_ROLL) ||
                                     (cmd.job == djsg_pkg::JOB_TILT));
      step_hit = prod_ff > djsg_pkg::PROD_W'(thresh_ff);
      step_m   = ~step_ff[0];

      roll_vel_in = cmd.load_roll ? req_velocity : roll_vel_ff;
      tilt_vel_in = cmd.load_tilt ? req_velocity : tilt_vel_ff;
      mv_in       = mv_ff;
      step_in     = step_ff;
      roll_res_in = roll_res_ff;
      tilt_res_in = tilt_res_ff;
      place_in    = place_ff;
      ticks_in    = ticks_ff;
      axis_in     = axis_ff;

      if (cmd.wr) begin
         unique case (cmd.job)
            djsg_pkg::JOB_MIX_A: mv_in[0]    = wr_val;
            djsg_pkg::JOB_MIX_B: mv_in[1]    = wr_val;
            djsg_pkg::JOB_CHK_A: step_in[0]  = step_hit;
            djsg_pkg::JOB_CHK_B: step_in[1]  = step_hit;
            djsg_pkg::JOB_ROLL:  roll_res_in = wr_val;
            djsg_pkg::JOB_TILT:  tilt_res_in = wr_val;
            default: ;
         endcase
      end

      // saturating counters, both motors on every tick
      if (cmd.tick) begin
         for (int m = 0; m < 2; m++) begin
            ticks_in[m] = (ticks_ff[m] == djsg_pkg::TICK_MAX) ? ticks_ff[m]
                                                               : ticks_ff[m] + 32'd1;
         end
      end

      step_ext  = mv_ff[step_m][DW-1] ? -(DW+1)'(step_size_ff) : (DW+1)'(step_size_ff);
      place_sum = (DW+1)'(place_ff[step_m]) + step_ext;
      if (cmd.step) begin
         axis_in          = step_m;
         step_in[step_m]  = 1'b0;
         ticks_in[step_m] = '0;
         if (place_sum[DW] != place_sum[DW-1]) begin
            place_in[step_m] = place_sum[DW] ? djsg_pkg::NEG_MIN : djsg_pkg::POS_MAX;
         end else begin
            place_in[step_m] = place_sum[DW-1:0];
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_axis_in  = out_axis_ff;
      out_motor_in = out_motor_ff;
      out_roll_in  = out_roll_ff;
      out_tilt_in  = out_tilt_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_axis_in  = axis_ff;
         out_motor_in = place_ff[axis_ff];
         out_roll_in  = roll_res_ff;
         out_tilt_in  = tilt_res_ff;
         out_last_in  = ~(step_ff[0] | step_ff[1]);
      end
   end

   assign status.any_step  = step_ff[0] | step_ff[1];
   assign status.out_busy  = out_valid_ff & ~rsp_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_motor_axis     = out_axis_ff;
   assign rsp_motor_position = out_motor_ff;
   assign rsp_roll_position  = out_roll_ff;
   assign rsp_tilt_position  = out_tilt_ff;
   assign rsp_last           = out_last_ff;

endmodule
`default_nettype wire

// ===== hdl/differential_joint_step_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// differential_joint_step_generator
// Differential wrist mixer with a per-millisecond step generator for two motors.
// ----------------------------------------------------------------------------
// Roll and tilt velocity commands (Q16.16 rad/s) are mixed into two motor
// velocities, A = gain*(tilt-roll) and B = gain*(-roll-tilt). Each tick
// transaction advances both step counters and then lets motor A, then motor B,
// take one step of step_size once ticks*|v| exceeds step_size*TICKS_PER_SECOND;
// every step yields one response transaction with the motor position and the
// joint positions, last marking the final one of the tick. All products run
// through a single 32x32 multiplier, each in an operand, a multiply and a
// saturate-and-write-back state; a step's response waits until the previous
// one is taken on rsp ready. A write of speed_gain remixes the motor
// velocities, holding off requests until the remix is done.
// ----------------------------------------------------------------------------
module differential_joint_step_generator #(
   parameter int TICKS_PER_SECOND = djsg_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   djsg_req_if.sink                            req,
   djsg_rsp_if.source                          rsp,
   input  wire logic                           csr_write_enable,
   input  wire logic [djsg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [djsg_pkg::DATA_W-1:0]    csr_write_data
);

   djsg_pkg::dp_cmd_type    cmd;
   djsg_pkg::dp_status_type status;
   logic                    req_ready;
   logic                    csr_gain_write;

   // a new speed gain needs the motor velocities remixed
   assign csr_gain_write = csr_write_enable &&
                           (csr_index == djsg_pkg::REG_SPEED_GAIN);

   djsg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_command    (req.command),
      .req_ready      (req_ready),
      .csr_gain_write (csr_gain_write),
      .status         (status),
      .cmd            (cmd)
   );

   djsg_dp #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_velocity       (req.velocity),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_motor_axis     (rsp.motor_axis),
      .rsp_motor_position (rsp.motor_position),
      .rsp_roll_position  (rsp.roll_position),
      .rsp_tilt_position  (rsp.tilt_position),
      .rsp_last           (rsp.last)
   );

   // request side is taken only when the sequencer is idle
   assign req.ready = req_ready;

   // a tick keeps the sequencer busy for at least the threshold checks
   a_tick_busy : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.command == djsg_pkg::CMD_TICK)) |=> !req.ready)
      else $error("request taken right after a tick");

   // motor B is the later of the two steps, so a non-final response is motor A
   a_first_is_a : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.last) |-> (rsp.motor_axis == 1'b0))
      else $error("non-final response not from motor A");

   // a speed gain write holds off requests until the remix is done
   a_remix_holds : assert property (@(posedge clock) disable iff (reset)
      csr_gain_write |=> !req.ready)
      else $error("request taken before remix");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential wrist step generator.
// ----------------------------------------------------------------------------
// Requests go out from a backlog queue. The sender runs in random bursts with
// random gaps. The receiver stalls on a windowed pattern of its own, and
// sometimes holds off for a long stretch. Each accepted request is run through
// a bit-true predictor of the mixer and step generator. Each motor step it
// predicts is queued and then compared field by field with the next response
// transaction. The run covers a directed opening, randomized phases under
// several register settings, and a short climb of motor A at full rate with
// the joint products pinned.
// ----------------------------------------------------------------------------
module tb_top;
   import djsg_pkg::*;

   localparam int TICK_RATE     = TICKS_PER_SECOND_DEFAULT;
   localparam int SETTLE_CYCLES = 16;        // long enough for a tick with no step to finish
   localparam int LONG_HOLD     = 400;       // long receiver hold-off, in cycles
   localparam int RANDOM_ITEMS  = 720;
   localparam int RANDOM_STEPS  = 60;
   localparam int PHASE_ITEMS   = 90;
   localparam int CLIMB_TICKS   = 64;
   localparam longint RUN_LIMIT = 10_000_000;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, block ignores it

   localparam logic signed [33:0] PLACE_HI = 34'sh0_7fff_ffff;
   localparam logic signed [33:0] PLACE_LO = -34'sh0_8000_0000;

   typedef enum logic [1:0] {
      RX_OPEN,     // always ready
      RX_COIN,     // ready half the time
      RX_SPARSE    // ready one cycle in four
   } rx_pattern_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] velocity;
   } wrist_request_type;

   typedef struct packed {
      logic              motor_axis;
      logic [DATA_W-1:0] motor_position;
      logic [DATA_W-1:0] roll_position;
      logic [DATA_W-1:0] tilt_position;
      logic              last;
   } step_report_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // everything the bench drives, known from time zero
   logic              req_valid    = 1'b0;
   logic [CMD_W-1:0]  req_command  = '0;
   logic [DATA_W-1:0] req_velocity = '0;
   logic              rsp_ready    = 1'b0;

   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [DATA_W-1:0]    csr_write_data   = '0;

   djsg_req_if req_ch ();
   djsg_rsp_if rsp_ch ();

   assign req_ch.valid    = req_valid;
   assign req_ch.command  = req_command;
   assign req_ch.velocity = req_velocity;
   assign rsp_ch.ready    = rsp_ready;

   differential_joint_step_generator #(
      .TICKS_PER_SECOND (TICK_RATE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // queues between the processes
   wrist_request_type request_backlog [$];
   step_report_type   step_reports_due [$];

   int fault_count       = 0;
   int predicted_steps   = 0;
   int pressure_requests = 0;
   int pressure_served   = 0;

   // ------------------------------------------------------------------------
   // predictor state, starts at the reset values of the block
   // ------------------------------------------------------------------------
   logic [DATA_W-1:0] gain_speed     = SPEED_GAIN_RESET;
   logic [DATA_W-1:0] gain_inverse   = INVERSE_GAIN_RESET;
   logic [STEP_W-1:0] step_increment = STEP_SIZE_RESET;

   logic signed [DATA_W-1:0] roll_cmd = '0;
   logic signed [DATA_W-1:0] tilt_cmd = '0;
   logic signed [DATA_W-1:0] motor_rate  [2] = '{default: '0};
   logic signed [DATA_W-1:0] motor_place [2] = '{default: '0};
   logic [DATA_W-1:0]        ticks_since [2] = '{default: '0};

   // exact product of |value| and gain, shifted (truncating toward zero),
   // sign restored and clamped to a signed word
   function automatic logic [DATA_W-1:0] scale_saturate(input logic signed [33:0] value,
                                                        input logic [DATA_W-1:0] gain,
                                                        input logic halve);
      logic [33:0] magnitude;
      logic [65:0] product;
      logic [65:0] quotient;
      logic [DATA_W-1:0] result;
      magnitude = value[33] ? -value : value;
      product   = {32'd0, magnitude} * {34'd0, gain};
      quotient  = halve ? (product >> 17) : (product >> 16);
      if (!value[33]) begin
         result = (quotient > 66'h7fff_ffff) ? 32'h7fff_ffff : quotient[31:0];
      end else begin
         result = (quotient >= 66'h8000_0000) ? 32'h8000_0000 : 32'd0 - quotient[31:0];
      end
      return result;
   endfunction

   // motor A = gain*(tilt-roll), motor B = gain*(-roll-tilt)
   task automatic remix_motors();
      logic signed [33:0] roll_wide;
      logic signed [33:0] tilt_wide;
      roll_wide = roll_cmd;
      tilt_wide = tilt_cmd;
      motor_rate[0] = scale_saturate(tilt_wide - roll_wide, gain_speed, 1'b0);
      motor_rate[1] = scale_saturate(-roll_wide - tilt_wide, gain_speed, 1'b0);
   endtask

   task automatic load_register(input reg_index_type idx, input logic [DATA_W-1:0] value);
      case (idx)
         REG_SPEED_GAIN: begin
            gain_speed = value;
            remix_motors();
         end
         REG_INVERSE_GAIN: begin
            gain_inverse = value;
         end
         REG_STEP_SIZE: begin
            step_increment = value[STEP_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // one accepted request: update the mix, or run a tick and queue its steps
   task automatic advance_wrist(input logic [CMD_W-1:0] command,
                                input logic [DATA_W-1:0] velocity);
      step_report_type    fresh [$];
      step_report_type    entry;
      logic signed [32:0] rate_wide;
      logic [32:0]        rate_mag;
      logic [64:0]        progress;
      logic [64:0]        threshold;
      logic signed [33:0] place_wide;
      logic signed [33:0] stride;
      logic signed [33:0] a_wide;
      logic signed [33:0] b_wide;
      if (command == CMD_ROLL) begin
         roll_cmd = velocity;
         remix_motors();
      end else if (command == CMD_TILT) begin
         tilt_cmd = velocity;
         remix_motors();
      end else if (command == CMD_TICK) begin
         // both counters advance on every tick, saturating at all ones
         for (int m = 0; m < 2; m++) begin
            if (ticks_since[m] != TICK_MAX) ticks_since[m] = ticks_since[m] + 1;
         end
         threshold = {49'd0, step_increment} * 65'(TICK_RATE);
         // motor A first, then motor B; strict comparison against the threshold
         for (int m = 0; m < 2; m++) begin
            rate_wide = motor_rate[m];
            rate_mag  = rate_wide[32] ? -rate_wide : rate_wide;
            progress  = {32'd0, rate_mag} * {33'd0, ticks_since[m]};
            if (motor_rate[m] != 0 && progress > threshold) begin
               stride     = $signed({18'd0, step_increment});
               place_wide = motor_place[m];
               place_wide = rate_wide[32] ? place_wide - stride : place_wide + stride;
               if (place_wide > PLACE_HI) place_wide = PLACE_HI;
               if (place_wide < PLACE_LO) place_wide = PLACE_LO;
               motor_place[m] = place_wide[31:0];
               ticks_since[m] = '0;
               a_wide = motor_place[0];
               b_wide = motor_place[1];
               entry.motor_axis     = (m == 1);
               entry.motor_position = motor_place[m];
               entry.roll_position  = scale_saturate(-a_wide - b_wide, gain_inverse, 1'b1);
               entry.tilt_position  = scale_saturate(a_wide - b_wide, gain_inverse, 1'b1);
               entry.last           = 1'b0;
               fresh.push_back(entry);
               predicted_steps++;
            end
         end
         // last marks the final step of this tick
         for (int i = 0; i < fresh.size(); i++) begin
            entry      = fresh[i];
            entry.last = (i == fresh.size() - 1);
            step_reports_due.push_back(entry);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sender: bursts of random length, random gaps in between
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_requests
      wrist_request_type next_item;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ch.ready) begin
         // slot is free: nothing on offer, or the offer was taken at this edge
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            next_item    = request_backlog.pop_front();
            req_valid    <= 1'b1;
            req_command  <= next_item.command;
            req_velocity <= next_item.velocity;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: pattern changes every window; a long hold-off when asked
   // ------------------------------------------------------------------------
   rx_pattern_type rx_mode     = RX_OPEN;
   int             window_left = 0;
   int             hold_left   = 0;

   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready   <= 1'b0;
         window_left <= 0;
         hold_left   <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_served < pressure_requests && step_reports_due.size() != 0) begin
         // a response is pending: sit on it so the block backs up into req
         rsp_ready       <= 1'b0;
         hold_left       <= LONG_HOLD;
         pressure_served <= pressure_served + 1;
      end else begin
         if (window_left == 0) begin
            rx_mode     <= rx_pattern_type'($urandom_range(0, 2));
            window_left <= $urandom_range(16, 96);
         end else begin
            window_left <= window_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: responses are checked before the same edge's request is
   // predicted, since a response always belongs to an earlier request
   // ------------------------------------------------------------------------
   task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (want !== got) begin
         fault_count++;
         $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      step_report_type seen;
      step_report_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ready) begin
            seen.motor_axis     = rsp_ch.motor_axis;
            seen.motor_position = rsp_ch.motor_position;
            seen.roll_position  = rsp_ch.roll_position;
            seen.tilt_position  = rsp_ch.tilt_position;
            seen.last           = rsp_ch.last;
            if (step_reports_due.size() == 0) begin
               fault_count++;
               $error("response transaction with no step predicted: axis %0d pos 0x%08h",
                      seen.motor_axis, seen.motor_position);
            end else begin
               want = step_reports_due.pop_front();
               compare_field("motor_axis", 32'(want.motor_axis), 32'(seen.motor_axis));
               compare_field("motor_position", want.motor_position, seen.motor_position);
               compare_field("roll_position", want.roll_position, seen.roll_position);
               compare_field("tilt_position", want.tilt_position, seen.tilt_position);
               compare_field("last", 32'(want.last), 32'(seen.last));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            advance_wrist(req_command, req_velocity);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic offer(input logic [CMD_W-1:0] command, input logic [DATA_W-1:0] velocity);
      wrist_request_type item;
      item.command  = command;
      item.velocity = velocity;
      request_backlog.push_back(item);
   endtask

   task automatic offer_ticks(input int count);
      repeat (count) offer(CMD_TICK, $urandom);
   endtask

   // wait until every request is taken and every step has come back, then let
   // a tick that steps nothing finish inside the block; sampled on the falling
   // edge so the sender's updates at the rising edge are settled
   task automatic drain_and_settle();
      while (request_backlog.size() != 0 || req_valid || step_reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      load_register(idx, value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // speed_gain goes last so its remix starts after the other writes
   task automatic program_wrist(input logic [DATA_W-1:0] speed, input logic [DATA_W-1:0] inverse,
                                input logic [STEP_W-1:0] step);
      write_register(REG_STEP_SIZE, {16'd0, step});
      write_register(REG_INVERSE_GAIN, inverse);
      write_register(REG_SPEED_GAIN, speed);
   endtask

   // mix of huge, moderate, small, zero and corner velocities
   function automatic logic [DATA_W-1:0] pick_velocity();
      int unsigned kind;
      int          signed_value;
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
         return $urandom;
      end else if (kind <= 5) begin
         signed_value = int'($urandom_range(0, 2097152)) - 1048576;
         return signed_value;
      end else if (kind <= 7) begin
         signed_value = int'($urandom_range(0, 32768)) - 16384;
         return signed_value;
      end else if (kind == 8) begin
         return '0;
      end
      case ($urandom_range(0, 3))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int          random_items;
      int          steps_at_start;
      int          phase;
      int          placed;
      int unsigned roll_dice;
      logic [DATA_W-1:0] speed;
      logic [DATA_W-1:0] inverse;
      logic [STEP_W-1:0] step;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      offer(CMD_SPARE, 32'hffff_ffff);   // unused code: no response, no state change
      offer_ticks(1);                    // both motors stopped, counters still run
      offer(CMD_ROLL, 32'h7fff_ffff);    // full positive roll, both motors negative
      offer_ticks(2);                    // both step on each tick, last on motor B
      offer(CMD_ROLL, 32'h8000_0000);
      offer(CMD_TILT, 32'h7fff_ffff);    // A mix saturates, B mixes down to zero
      offer_ticks(1);                    // only motor A steps
      offer(CMD_TILT, 32'h8000_0000);    // A stops, B mix saturates
      offer_ticks(1);                    // only motor B steps, last on it
      offer(CMD_ROLL, '0);
      offer(CMD_TILT, '0);
      offer_ticks(1);
      drain_and_settle();

      // unity gain: ticks*82000 meets 328000 exactly on the fourth count,
      // the strict compare holds the step until the fifth
      program_wrist(32'h0001_0000, 32'hffff_ffff, STEP_SIZE_RESET);
      offer(CMD_TILT, 32'd82000);
      offer_ticks(5);
      offer(CMD_TILT, '0);
      drain_and_settle();

      // zero step size: steps still fire every tick but positions stay put
      write_register(REG_STEP_SIZE, '0);
      offer(CMD_TILT, 32'h0001_0000);
      offer_ticks(2);
      offer(CMD_TILT, '0);
      drain_and_settle();

      // randomized phases, each under its own register setting
      random_items   = 0;
      steps_at_start = predicted_steps;
      phase          = 0;
      while ((random_items < RANDOM_ITEMS || predicted_steps - steps_at_start < RANDOM_STEPS)
             && phase < 24) begin
         case (phase % 8)
            0: begin
               speed = SPEED_GAIN_RESET; inverse = INVERSE_GAIN_RESET; step = STEP_SIZE_RESET;
            end
            1: begin
               speed = '0; inverse = 32'h0001_0000; step = 16'd1;
            end
            2: begin
               speed = 32'hffff_ffff; inverse = 32'hffff_ffff; step = 16'hffff;
            end
            3: begin
               speed = 32'h0001_0000; inverse = '0; step = 16'd1;
            end
            4: begin
               speed   = $urandom_range(8192, 262144);
               inverse = $urandom;
               step    = STEP_W'($urandom_range(1, 2000));
            end
            5: begin
               speed = 32'h0002_0000; inverse = 32'h0002_0000; step = 16'd100;
            end
            6: begin
               speed   = $urandom;
               inverse = $urandom;
               step    = STEP_W'($urandom_range(1, 65535));
            end
            default: begin
               speed   = $urandom_range(8192, 262144);
               inverse = $urandom_range(65536, 262144);
               step    = STEP_W'($urandom_range(1, 65535));
            end
         endcase
         program_wrist(speed, inverse, step);

         // long receiver hold-off while the sender keeps offering
         if (phase % 8 == 2 || phase % 8 == 5) pressure_requests++;

         placed = 0;
         while (placed < PHASE_ITEMS) begin
            roll_dice = $urandom_range(0, 99);
            if (roll_dice < 7) begin
               offer(CMD_ROLL, pick_velocity());
               placed++;
            end else if (roll_dice < 14) begin
               offer(CMD_TILT, pick_velocity());
               placed++;
            end else if (roll_dice < 17) begin
               offer(CMD_SPARE, $urandom);
            end else begin
               offer_ticks(1);
               placed++;
            end
         end
         random_items += placed;
         drain_and_settle();
         phase++;
      end

      // climb: motor A at full rate and full step, with joint products pinned
      // by the maximal inverse gain, then a turn back down
      program_wrist(32'hffff_ffff, 32'hffff_ffff, 16'hffff);
      offer(CMD_ROLL, 32'h8000_0000);
      offer(CMD_TILT, 32'h7fff_ffff);
      drain_and_settle();
      offer_ticks(CLIMB_TICKS);
      offer(CMD_ROLL, 32'h7fff_ffff);    // turn around and step back down
      offer_ticks(3);
      drain_and_settle();

      if (fault_count == 0 && step_reports_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
